[sv/sopt_pkg.sv]
// ----------------------------------------------------------------------------
// Sonar occupancy pan tracker package
// Shared constants, types and the pan command table.
// ----------------------------------------------------------------------------
package sopt_pkg;

  localparam int NumSonars = 12;
  localparam int IdxW      = 4;
  localparam int LvlW      = 16;
  localparam int IncrW     = 20;
  localparam int DistW     = 16;
  localparam int MaskW     = 12;
  localparam int CmdMilliW = 11;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 20;
  localparam int DivSteps  = IncrW / 2;
  localparam int DivCntW   = 4;

  localparam logic [LvlW-1:0]  FullScale    = 16'd32768;
  localparam logic [IncrW-1:0] IncrReset    = 20'd327680;
  localparam logic [LvlW-1:0]  DecayReset   = 16'd22938;
  localparam logic [LvlW-1:0]  ThreshReset  = 16'd13107;
  localparam logic [MaskW-1:0] MaskReset    = 12'd224;

  typedef enum logic [CfgIdxW-1:0] {
    CfgIncr   = 2'd0,
    CfgDecay  = 2'd1,
    CfgThresh = 2'd2,
    CfgMask   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ItemReading = 1'b0,
    ItemTick    = 1'b1
  } item_cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StUpd,
    StScan,
    StFin
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic lvl_wr;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic skip;
    logic div_done;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

  function automatic logic signed [CmdMilliW-1:0] pan_command(logic [IdxW-1:0] idx);
    logic signed [CmdMilliW-1:0] val;
    val = '0;
    unique case (idx)
      4'd0:    val = 11'sd0;
      4'd1:    val = -11'sd333;
      4'd2:    val = -11'sd667;
      4'd3:    val = -11'sd1000;
      4'd4:    val = -11'sd1000;
      4'd5:    val = 11'sd1000;
      4'd6:    val = 11'sd1000;
      4'd7:    val = 11'sd1000;
      4'd8:    val = 11'sd1000;
      4'd9:    val = 11'sd997;
      4'd10:   val = 11'sd663;
      4'd11:   val = 11'sd330;
      default: val = 11'sd0;
    endcase
    return val;
  endfunction

endpackage

[sv/sopt_intf.sv]
// ----------------------------------------------------------------------------
// Sonar occupancy pan tracker channels
// Valid/ready channels for input items and for pan results.
// ----------------------------------------------------------------------------
interface sopt_in_if import sopt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IdxW-1:0]  sensor_id;
  logic [DistW-1:0] distance_mm;

  modport source (output valid, output cmd, output sensor_id, output distance_mm,
                  input ready);
  modport sink (input valid, input cmd, input sensor_id, input distance_mm,
                output ready);
endinterface

interface sopt_out_if import sopt_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        move_valid;
  logic [IdxW-1:0]             target_index;
  logic signed [CmdMilliW-1:0] command_milli;
  logic [LvlW-1:0]             peak_level;

  modport source (output valid, output move_valid, output target_index,
                  output command_milli, output peak_level, input ready);
  modport sink (input valid, input move_valid, input target_index,
                input command_milli, input peak_level, output ready);
endinterface

[sv/sonar_occupancy_pan_tracker.sv]
// ----------------------------------------------------------------------------
// Sonar occupancy pan tracker
// A reading loads the divider in its transfer cycle; the divider steps then
// give two quotient bits each, and the update state writes the level.
// A masked or out-of-range reading is finished in its transfer cycle.
// A tick walks the 12 levels for the peak and the decay, then loads the result
// register once it is free. No new item is taken until the last is done.
// Reset clears all levels to zero and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module sonar_occupancy_pan_tracker import sopt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sopt_in_if.sink             in_if,
  sopt_out_if.source          out_if
);

  ctrl_cmd_t    ctrl_cmd;
  ctrl_status_t ctrl_status;
  logic         in_ready;

  assign in_if.ready = in_ready;

  sopt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (ctrl_status),
    .cmd_o      (ctrl_cmd)
  );

  sopt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_cmd_i         (in_if.cmd),
    .in_sensor_id_i   (in_if.sensor_id),
    .in_distance_mm_i (in_if.distance_mm),
    .cmd_i            (ctrl_cmd),
    .status_o         (ctrl_status),
    .out_if           (out_if)
  );

endmodule

[sv/sopt_ctrl.sv]
// ----------------------------------------------------------------------------
// Sonar occupancy pan tracker controller
// Sequences the divider, the level update and the tick scan.
// ----------------------------------------------------------------------------
module sopt_ctrl import sopt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (status_i.is_tick) begin
            state_d = StScan;
          end else if (!status_i.skip) begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (status_i.div_done) begin
          state_d = StUpd;
        end
      end
      StUpd: state_d = StIdle;
      StScan: begin
        if (status_i.scan_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.div_step  = (state_q == StDiv);
    cmd_o.lvl_wr    = (state_q == StUpd);
    cmd_o.scan_step = (state_q == StScan);
    cmd_o.out_load  = (state_q == StFin) && status_i.out_free;
  end

endmodule

[sv/sopt_dp.sv]
// ----------------------------------------------------------------------------
// Sonar occupancy pan tracker datapath
// Registers, levels, radix-4 restoring divider, scan and result register.
// ----------------------------------------------------------------------------
module sopt_dp import sopt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_cmd_i,
  input  logic [IdxW-1:0]     in_sensor_id_i,
  input  logic [DistW-1:0]    in_distance_mm_i,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_status_t        status_o,
  sopt_out_if.source          out_if
);

  logic [IncrW-1:0]   incr_q;
  logic [LvlW-1:0]    decay_q;
  logic [LvlW-1:0]    thresh_q;
  logic [MaskW-1:0]   mask_q;

  logic [LvlW-1:0]    level_q [NumSonars];
  logic [IdxW-1:0]    id_q;
  logic [DistW-1:0]   dist_q;
  logic [IncrW-1:0]   nq_q, nq_d;
  logic [DistW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] div_cnt_q;
  logic [IdxW-1:0]    idx_q;
  logic [LvlW-1:0]    peak_q;
  logic [IdxW-1:0]    win_q;

  logic                        out_valid_q;
  logic                        move_q;
  logic [IdxW-1:0]             target_q;
  logic signed [CmdMilliW-1:0] milli_q;
  logic [LvlW-1:0]             peak_out_q;

  logic [15:0]        mask_ext;
  logic [IdxW-1:0]    rd_addr;
  logic [LvlW-1:0]    lvl_rd;
  logic [DistW:0]     t1, t2;
  logic               ge1, ge2;
  logic [DistW-1:0]   r1;
  logic [LvlW-1:0]    gain;
  logic [LvlW:0]      sum;
  logic [LvlW-1:0]    upd_lvl;
  logic [LvlW-1:0]    dec_lvl;
  logic               move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incr_q   <= IncrReset;
      decay_q  <= DecayReset;
      thresh_q <= ThreshReset;
      mask_q   <= MaskReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIncr:   incr_q   <= cfg_data_i[IncrW-1:0];
        CfgDecay:  decay_q  <= cfg_data_i[LvlW-1:0];
        CfgThresh: thresh_q <= cfg_data_i[LvlW-1:0];
        CfgMask:   mask_q   <= cfg_data_i[MaskW-1:0];
        default:   ;
      endcase
    end
  end

  assign mask_ext = {{(16 - MaskW){1'b0}}, mask_q};

  always_comb begin
    status_o           = '0;
    status_o.is_tick   = (in_cmd_i == ItemTick);
    status_o.skip      = (in_sensor_id_i >= IdxW'(NumSonars)) || mask_ext[in_sensor_id_i];
    status_o.div_done  = (div_cnt_q == DivCntW'(DivSteps - 1));
    status_o.scan_done = (idx_q == IdxW'(NumSonars - 1));
    status_o.out_free  = !out_valid_q || out_if.ready;
  end

  // Two restoring quotient bits per cycle.
  always_comb begin
    t1    = {rem_q, nq_q[IncrW-1]};
    ge1   = (t1 >= {1'b0, dist_q});
    r1    = ge1 ? DistW'(t1 - {1'b0, dist_q}) : t1[DistW-1:0];
    t2    = {r1, nq_q[IncrW-2]};
    ge2   = (t2 >= {1'b0, dist_q});
    rem_d = ge2 ? DistW'(t2 - {1'b0, dist_q}) : t2[DistW-1:0];
    nq_d  = {nq_q[IncrW-3:0], ge1, ge2};
  end

  assign rd_addr = cmd_i.scan_step ? idx_q : id_q;
  assign lvl_rd  = level_q[rd_addr];

  always_comb begin
    gain    = (nq_q > {{(IncrW - LvlW){1'b0}}, FullScale}) ? FullScale : nq_q[LvlW-1:0];
    sum     = {1'b0, lvl_rd} + {1'b0, gain};
    upd_lvl = (sum > {1'b0, FullScale}) ? FullScale : sum[LvlW-1:0];
    dec_lvl = (lvl_rd > decay_q) ? LvlW'(lvl_rd - decay_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSonars; i++) begin
        level_q[i] <= '0;
      end
    end else if (cmd_i.lvl_wr) begin
      level_q[id_q] <= upd_lvl;
    end else if (cmd_i.scan_step) begin
      level_q[idx_q] <= dec_lvl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= in_sensor_id_i;
      dist_q <= in_distance_mm_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nq_q      <= '0;
      rem_q     <= '0;
      div_cnt_q <= '0;
      idx_q     <= '0;
      peak_q    <= '0;
      win_q     <= '0;
    end else if (cmd_i.load) begin
      nq_q      <= incr_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
      idx_q     <= '0;
      peak_q    <= '0;
      win_q     <= '0;
    end else begin
      if (cmd_i.div_step) begin
        nq_q      <= nq_d;
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + IdxW'(1);
        if (lvl_rd > peak_q) begin
          peak_q <= lvl_rd;
          win_q  <= idx_q;
        end
      end
    end
  end

  assign move = (peak_q != '0) && (peak_q >= thresh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      move_q     <= move;
      target_q   <= move ? win_q : '0;
      milli_q    <= move ? pan_command(win_q) : '0;
      peak_out_q <= peak_q;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.move_valid    = move_q;
  assign out_if.target_index  = target_q;
  assign out_if.command_milli = milli_q;
  assign out_if.peak_level    = peak_out_q;

endmodule
